// ===== sv/cascaded_pid_motor_loop_unit_macros.svh =====
// Assertion macros used by the motor loop controller.
`ifndef CASCADED_PID_MOTOR_LOOP_UNIT_MACROS_SVH
`define CASCADED_PID_MOTOR_LOOP_UNIT_MACROS_SVH
`ifndef SYNTHESIS
`define CPML_ASSERT_IMP(lbl, a, b) \
lbl: assert property (@(posedge clk) disable iff (!arst_n) (a) |-> (b)) \
	else $error("cpml: assertion failed");
`define CPML_ASSERT_NXT(lbl, a, b) \
lbl: assert property (@(posedge clk) disable iff (!arst_n) (a) |=> (b)) \
	else $error("cpml: assertion failed");
`else
`define CPML_ASSERT_IMP(lbl, a, b)
`define CPML_ASSERT_NXT(lbl, a, b)
`endif
`endif

// ===== sv/cpml_pkg.sv =====
// Types, constants and helpers of the cascaded motor loop.
`timescale 1ns / 1ps
package cpml_pkg;
	localparam int Motors = 8;
	localparam int MotorW = 3;
	localparam int CurrentLimit = 15000;
	localparam int TurnStep = 3000;
	localparam int Deadband = 10;

	typedef enum logic [1:0] {
		MODE_CASCADE = 2'd0,
		MODE_VEL     = 2'd1,
		MODE_CAP     = 2'd2
	} mode_t;

	typedef enum logic [2:0] {
		REG_POS_KP  = 3'd0,
		REG_POS_KI  = 3'd1,
		REG_POS_KD  = 3'd2,
		REG_VEL_KP  = 3'd3,
		REG_VEL_KI  = 3'd4,
		REG_VEL_KD  = 3'd5,
		REG_POS_LIM = 3'd6,
		REG_VEL_LIM = 3'd7
	} reg_idx_t;

	typedef enum logic [3:0] {
		ST_IDLE, ST_UNWRAP, ST_PPREP, ST_PMUL0, ST_PMUL1, ST_PMUL2, ST_PACC,
		ST_VSET, ST_VPREP, ST_VMUL0, ST_VMUL1, ST_VMUL2, ST_VACC, ST_VSAT, ST_DONE
	} state_t;

	typedef struct packed {
		logic       cap;
		logic       unwrap;
		logic       pprep;
		logic       vset;
		logic       vprep;
		logic       mul_en;
		logic [1:0] mul_idx;
		logic       acc_add;
		logic       vacc;
		logic       fin;
	} cmd_t;

	typedef struct packed {
		logic motor_ok;
		logic vel_only;
		logic out_busy;
	} sts_t;

	function automatic logic signed [31:0] sat32(input logic signed [49:0] x);
		logic signed [31:0] r;
		if (x > 50'sd2147483647) r = 32'sh7fffffff;
		else if (x < -50'sd2147483648) r = 32'sh80000000;
		else r = x[31:0];
		return r;
	endfunction
endpackage

// ===== sv/cascaded_pid_motor_loop_unit.sv =====
// Top level of the cascaded position and velocity PID motor loop.
//  Channel   Direction  Signals
//  s_axis    in         tvalid/tready, tuser = motor, mode; tdata = sample and targets
//  m_axis    out        tvalid/tready, tuser = motor_out; tdata = current, position, setpoint
//  cfg       in         cfg_valid/cfg_ready, cfg_index, cfg_data
// In position modes a sample passes the position and then the velocity PID loop, in velocity mode only the
// velocity loop; both use the single shared 32 by 32 multiplier that runs three products per PID loop.
// Reset clears gains, limits and all per-motor state at once.
// A new sample is taken while a result waits in the output register; a stalled result holds
// the controller before it writes the next one.
`timescale 1ns / 1ps
module cascaded_pid_motor_loop_unit (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [4:0]  s_axis_tuser,  // motor[2:0], mode[4:3]
	input  logic [87:0] s_axis_tdata,  // angle, speed, target_position, target_velocity
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [2:0]  m_axis_tuser,  // motor_out
	output logic [79:0] m_axis_tdata,  // current, position, velocity_setpoint
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [2:0]  cfg_index,
	input  logic [31:0] cfg_data
);
	import cpml_pkg::*;

	cmd_t cmd;
	sts_t sts;

	assign cfg_ready = 1'b1;

	cpml_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_axis_tvalid),
		.in_ready (s_axis_tready),
		.sts      (sts),
		.cmd      (cmd)
	);

	cpml_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.sts       (sts),
		.cfg_valid (cfg_valid),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.in_user   (s_axis_tuser),
		.in_data   (s_axis_tdata),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.out_user  (m_axis_tuser),
		.out_data  (m_axis_tdata)
	);
endmodule

// ===== sv/cpml_dp.sv =====
// Datapath of the motor loop: registers, per-motor state, PID arithmetic, result register.
`timescale 1ns / 1ps
module cpml_dp (
	input  logic              clk,
	input  logic              arst_n,
	input  cpml_pkg::cmd_t    cmd,
	output cpml_pkg::sts_t    sts,
	input  logic              cfg_valid,
	input  logic [2:0]        cfg_index,
	input  logic [31:0]       cfg_data,
	input  logic [4:0]        in_user,
	input  logic [87:0]       in_data,
	output logic              out_valid,
	input  logic              out_ready,
	output logic [2:0]        out_user,
	output logic [79:0]       out_data
);
	import cpml_pkg::*;

	logic signed [31:0] pos_kp_q, pos_ki_q, pos_kd_q, vel_kp_q, vel_ki_q, vel_kd_q;
	logic [30:0]        pos_lim_q, vel_lim_q;

	logic [MotorW-1:0]  motor_q;
	logic [1:0]         mode_q;
	logic [12:0]        angle_q;
	logic signed [15:0] speed_q;
	logic signed [31:0] tpos_q;
	logic signed [23:0] tvel_q;

	logic               seen_q   [Motors];
	logic [12:0]        last_q   [Motors];
	logic [12:0]        origin_q [Motors];
	logic [15:0]        turns_q  [Motors];
	logic signed [31:0] psum_q   [Motors];
	logic signed [31:0] pprev_q  [Motors];
	logic signed [31:0] vsum_q   [Motors];
	logic signed [31:0] vprev_q  [Motors];
	logic signed [47:0] accum_q  [Motors];

	logic signed [31:0] pos_q, vsp_q, e_q, s_q, d_q;
	logic               loop_q;
	logic signed [63:0] prod_q;
	logic signed [65:0] acc_q;
	logic [14:0]        cur_q;
	logic               out_valid_q;
	logic [2:0]         out_user_q;
	logic [79:0]        out_data_q;

	logic               seen_w;
	logic [12:0]        last_w, org_w;
	logic [15:0]        turns_w, turns_new;
	logic signed [13:0] diff_w;
	logic signed [31:0] ts_w, pos_new;
	logic signed [31:0] err_w, sum_old, prev_old, s_new, d_new, e_new;
	logic [30:0]        lim_w;
	logic signed [33:0] s34, lim34;
	logic signed [32:0] d33, perr33, verr33;
	logic signed [31:0] ma, mb, tvel32, vsp_pid, vsp_new;
	logic signed [49:0] pid_out;
	logic signed [32:0] abs_vsp, abs_tvel;
	logic signed [50:0] acc_sum;
	logic signed [47:0] acc_new;
	logic signed [47:0] cur_w;

	assign sts.motor_ok = ({1'b0, in_user[2:0]} < 4'(Motors)) || cmd.unwrap || !cmd.cap;
	assign sts.vel_only = (mode_q == MODE_VEL);
	assign sts.out_busy = out_valid_q && !out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_kp_q <= '0; pos_ki_q <= '0; pos_kd_q <= '0;
			vel_kp_q <= '0; vel_ki_q <= '0; vel_kd_q <= '0;
			pos_lim_q <= '0; vel_lim_q <= '0;
		end else if (cfg_valid) begin
			case (reg_idx_t'(cfg_index))
				REG_POS_KP:  pos_kp_q <= cfg_data;
				REG_POS_KI:  pos_ki_q <= cfg_data;
				REG_POS_KD:  pos_kd_q <= cfg_data;
				REG_VEL_KP:  vel_kp_q <= cfg_data;
				REG_VEL_KI:  vel_ki_q <= cfg_data;
				REG_VEL_KD:  vel_kd_q <= cfg_data;
				REG_POS_LIM: pos_lim_q <= cfg_data[30:0];
				REG_VEL_LIM: vel_lim_q <= cfg_data[30:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.cap) begin
			motor_q <= in_user[2:0];
			mode_q  <= in_user[4:3];
			angle_q <= in_data[12:0];
			speed_q <= in_data[28:13];
			tpos_q  <= in_data[60:29];
			tvel_q  <= in_data[84:61];
		end
	end

	always_comb begin
		seen_w  = seen_q[motor_q];
		last_w  = seen_w ? last_q[motor_q] : angle_q;
		org_w   = seen_w ? origin_q[motor_q] : angle_q;
		turns_w = seen_w ? turns_q[motor_q] : 16'd0;
		diff_w  = $signed({1'b0, angle_q}) - $signed({1'b0, last_w});
		if (diff_w > 14'(TurnStep)) turns_new = turns_w - 16'd1;
		else if (diff_w < -14'(TurnStep)) turns_new = turns_w + 16'd1;
		else turns_new = turns_w;
		ts_w    = {{16{turns_new[15]}}, turns_new};
		pos_new = (ts_w <<< 13) - ts_w + $signed({19'b0, angle_q}) - $signed({19'b0, org_w});
	end

	always_comb begin
		perr33   = {tpos_q[31], tpos_q} - {pos_q[31], pos_q};
		verr33   = {vsp_q[31], vsp_q} - {{17{speed_q[15]}}, speed_q};
		err_w    = cmd.pprep ? sat32(50'(perr33)) : sat32(50'(verr33));
		sum_old  = cmd.pprep ? psum_q[motor_q] : vsum_q[motor_q];
		prev_old = cmd.pprep ? pprev_q[motor_q] : vprev_q[motor_q];
		lim_w    = cmd.pprep ? pos_lim_q : vel_lim_q;
		lim34    = $signed({3'b0, lim_w});
		s34      = {{2{sum_old[31]}}, sum_old} + {{2{err_w[31]}}, err_w};
		d33      = {err_w[31], err_w} - {prev_old[31], prev_old};
		d_new    = sat32(50'(d33));
		e_new    = err_w;
		if ((err_w < 32'(Deadband)) && (err_w > -32'(Deadband))) begin
			e_new = '0;
			d_new = '0;
			s34   = '0;
		end
		if (s34 >= lim34) s34 = lim34;
		if (s34 <= -lim34) s34 = -lim34;
		s_new = s34[31:0];
	end

	always_comb begin
		case (cmd.mul_idx)
			2'd0:    begin ma = loop_q ? vel_kp_q : pos_kp_q; mb = e_q; end
			2'd1:    begin ma = loop_q ? vel_ki_q : pos_ki_q; mb = s_q; end
			default: begin ma = loop_q ? vel_kd_q : pos_kd_q; mb = d_q; end
		endcase
	end

	always_comb begin
		pid_out  = acc_q[65:16];
		tvel32   = {{8{tvel_q[23]}}, tvel_q};
		vsp_pid  = sat32(pid_out);
		abs_vsp  = vsp_pid[31] ? -{vsp_pid[31], vsp_pid} : {vsp_pid[31], vsp_pid};
		abs_tvel = tvel32[31] ? -{tvel32[31], tvel32} : {tvel32[31], tvel32};
		if (sts.vel_only) vsp_new = tvel32;
		else if ((mode_q == MODE_CAP) && (abs_vsp > abs_tvel)) vsp_new = tvel32;
		else vsp_new = vsp_pid;
		acc_sum = {{3{accum_q[motor_q][47]}}, accum_q[motor_q]} + {pid_out[49], pid_out};
		if (acc_sum > 51'sd140737488355327) acc_new = 48'sh7fffffffffff;
		else if (acc_sum < -51'sd140737488355328) acc_new = 48'sh800000000000;
		else acc_new = acc_sum[47:0];
		if (acc_new > 48'(CurrentLimit)) cur_w = 48'(CurrentLimit);
		else if (acc_new < -48'(CurrentLimit)) cur_w = -48'(CurrentLimit);
		else cur_w = acc_new;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < Motors; i++) begin
				seen_q[i] <= 1'b0; last_q[i] <= '0; origin_q[i] <= '0; turns_q[i] <= '0;
				psum_q[i] <= '0; pprev_q[i] <= '0; vsum_q[i] <= '0; vprev_q[i] <= '0;
				accum_q[i] <= '0;
			end
		end else begin
			if (cmd.unwrap) begin
				seen_q[motor_q]   <= 1'b1;
				last_q[motor_q]   <= angle_q;
				origin_q[motor_q] <= org_w;
				turns_q[motor_q]  <= turns_new;
			end
			if (cmd.pprep) begin
				psum_q[motor_q]  <= s_new;
				pprev_q[motor_q] <= err_w;
			end
			if (cmd.vprep) begin
				vsum_q[motor_q]  <= s_new;
				vprev_q[motor_q] <= err_w;
			end
			if (cmd.vacc) accum_q[motor_q] <= acc_new;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.cap) pos_q <= '0;
		else if (cmd.unwrap) pos_q <= pos_new;
		if (cmd.pprep || cmd.vprep) begin
			e_q    <= e_new;
			s_q    <= s_new;
			d_q    <= d_new;
			loop_q <= cmd.vprep;
		end
		if (cmd.mul_en) prod_q <= ma * mb;
		if (cmd.pprep || cmd.vprep) acc_q <= '0;
		else if (cmd.acc_add) acc_q <= acc_q + {{2{prod_q[63]}}, prod_q};
		if (cmd.cap) vsp_q <= '0;
		else if (cmd.vset) vsp_q <= vsp_new;
		if (cmd.cap) cur_q <= '0;
		else if (cmd.vacc) cur_q <= cur_w[14:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) out_valid_q <= 1'b0;
		else if (cmd.fin) out_valid_q <= 1'b1;
		else if (out_ready) out_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (cmd.fin) begin
			out_user_q <= motor_q;
			out_data_q <= {1'b0, vsp_q, pos_q, cur_q};
		end
	end

	assign out_valid = out_valid_q;
	assign out_user  = out_user_q;
	assign out_data  = out_data_q;
endmodule

// ===== sv/cpml_ctrl.sv =====
// Controller state machine that sequences one motor sample through the datapath.
`timescale 1ns / 1ps
`include "cascaded_pid_motor_loop_unit_macros.svh"
module cpml_ctrl (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	output logic           in_ready,
	input  cpml_pkg::sts_t sts,
	output cpml_pkg::cmd_t cmd
);
	import cpml_pkg::*;

	state_t state_q, state_d;

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE:   if (in_valid) state_d = sts.motor_ok ? ST_UNWRAP : ST_DONE;
			ST_UNWRAP: state_d = sts.vel_only ? ST_VSET : ST_PPREP;
			ST_PPREP:  state_d = ST_PMUL0;
			ST_PMUL0:  state_d = ST_PMUL1;
			ST_PMUL1:  state_d = ST_PMUL2;
			ST_PMUL2:  state_d = ST_PACC;
			ST_PACC:   state_d = ST_VSET;
			ST_VSET:   state_d = ST_VPREP;
			ST_VPREP:  state_d = ST_VMUL0;
			ST_VMUL0:  state_d = ST_VMUL1;
			ST_VMUL1:  state_d = ST_VMUL2;
			ST_VMUL2:  state_d = ST_VACC;
			ST_VACC:   state_d = ST_VSAT;
			ST_VSAT:   state_d = ST_DONE;
			ST_DONE:   if (!sts.out_busy) state_d = ST_IDLE;
			default:   state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		cmd = '0;
		in_ready = (state_q == ST_IDLE);
		case (state_q)
			ST_IDLE:   cmd.cap = in_valid;
			ST_UNWRAP: cmd.unwrap = 1'b1;
			ST_PPREP:  cmd.pprep = 1'b1;
			ST_PMUL0:  begin cmd.mul_en = 1'b1; cmd.mul_idx = 2'd0; end
			ST_PMUL1:  begin cmd.mul_en = 1'b1; cmd.mul_idx = 2'd1; cmd.acc_add = 1'b1; end
			ST_PMUL2:  begin cmd.mul_en = 1'b1; cmd.mul_idx = 2'd2; cmd.acc_add = 1'b1; end
			ST_PACC:   cmd.acc_add = 1'b1;
			ST_VSET:   cmd.vset = 1'b1;
			ST_VPREP:  cmd.vprep = 1'b1;
			ST_VMUL0:  begin cmd.mul_en = 1'b1; cmd.mul_idx = 2'd0; end
			ST_VMUL1:  begin cmd.mul_en = 1'b1; cmd.mul_idx = 2'd1; cmd.acc_add = 1'b1; end
			ST_VMUL2:  begin cmd.mul_en = 1'b1; cmd.mul_idx = 2'd2; cmd.acc_add = 1'b1; end
			ST_VACC:   cmd.acc_add = 1'b1;
			ST_VSAT:   cmd.vacc = 1'b1;
			ST_DONE:   cmd.fin = !sts.out_busy;
			default:   ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= ST_IDLE;
		else state_q <= state_d;
	end

	`CPML_ASSERT_IMP(a_fin_slot, cmd.fin, !sts.out_busy)
	`CPML_ASSERT_NXT(a_accept_go, (state_q == ST_IDLE) && in_valid, (state_q == ST_UNWRAP) || (state_q == ST_DONE))
	`CPML_ASSERT_NXT(a_vel_skip, (state_q == ST_UNWRAP) && sts.vel_only, state_q == ST_VSET)
	`CPML_ASSERT_IMP(a_one_step, 1'b1, $onehot0({cmd.cap, cmd.unwrap, cmd.pprep, cmd.vset, cmd.vprep, cmd.fin}))
endmodule
